### rtl/multi_client_watchdog_table_defines.svh
// Assertion macros shared by the watchdog table RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef MULTI_CLIENT_WATCHDOG_TABLE_DEFINES_SVH
`define MULTI_CLIENT_WATCHDOG_TABLE_DEFINES_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define MCWT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never becomes true outside reset.
`define MCWT_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### rtl/mcwt_pkg.sv
`timescale 1ns / 1ps

package mcwt_pkg;

  // Default configuration.
  localparam int SLOTS_DEF   = 16;
  localparam int ID_BITS_DEF = 16;

  // Field widths of the input and result beats.
  localparam int MODE_W     = 2;
  localparam int CLIENT_W   = 16;
  localparam int SLOT_IDX_W = 8;
  localparam int STATUS_W   = 3;
  localparam int ASSIGN_W   = 4;
  localparam int OCC_W      = 5;
  localparam int MASK_W     = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_SUB    = 2'd0,
    MODE_UNSUB  = 2'd1,
    MODE_KICK   = 2'd2,
    MODE_PERIOD = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_PRESENT = 3'd1,
    ST_FULL    = 3'd2,
    ST_RANGE   = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_REPORT
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the input beat, start a scan for subscribe
    logic exec;    // apply the table update
    logic report;  // load the result register, clear flags on period end
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic load_scan;  // the beat on the input ports is a subscribe
    logic scan_done;  // last slot compared this cycle
    logic out_free;   // result register can take a new beat
  } dp_status_t;

endpackage

### rtl/mcwt_ctrl.sv
`timescale 1ns / 1ps

module mcwt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  mcwt_pkg::dp_status_t  stat_i,
  output mcwt_pkg::ctrl_cmd_t   cmd_o
);
  import mcwt_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = stat_i.load_scan ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: begin
        if (stat_i.scan_done) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_REPORT;
      end
      S_REPORT: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o    = (state_q == S_IDLE);
    cmd_o.load    = (state_q == S_IDLE) && in_valid_i;
    cmd_o.exec    = (state_q == S_EXEC);
    cmd_o.report  = (state_q == S_REPORT) && stat_i.out_free;
  end

endmodule

### rtl/mcwt_dp.sv
`timescale 1ns / 1ps

module mcwt_dp #(
  parameter int SLOTS   = mcwt_pkg::SLOTS_DEF,
  parameter int ID_BITS = mcwt_pkg::ID_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mcwt_pkg::ctrl_cmd_t               cmd_i,
  output mcwt_pkg::dp_status_t              stat_o,
  input  logic [mcwt_pkg::MODE_W-1:0]       mode_i,
  input  logic [mcwt_pkg::CLIENT_W-1:0]     client_id_i,
  input  logic [mcwt_pkg::SLOT_IDX_W-1:0]   slot_index_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mcwt_pkg::STATUS_W-1:0]     status_o,
  output logic [mcwt_pkg::ASSIGN_W-1:0]     assigned_slot_o,
  output logic [mcwt_pkg::OCC_W-1:0]        occupied_count_o,
  output logic                              all_responsive_o,
  output logic [mcwt_pkg::MASK_W-1:0]       silent_mask_o
);
  import mcwt_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(SLOTS - 1);
  localparam logic [SLOT_IDX_W-1:0] SLOTS_LIM = SLOT_IDX_W'(SLOTS);

  // Captured input beat.
  mode_e                 mode_q;
  logic [ID_BITS-1:0]    id_q;
  logic [SLOT_IDX_W-1:0] idx_q;

  // Scan pipeline: address stage, then registered read data stage.
  logic                  issue_q;
  logic [IDX_W-1:0]      addr_q;
  logic                  rvalid_q;
  logic [IDX_W-1:0]      ridx_q;
  logic [ID_BITS-1:0]    rdata_q;

  logic                  present_q, present_d;
  logic                  free_found_q, free_found_d;
  logic [IDX_W-1:0]      free_idx_q, free_idx_d;

  // Slot table.
  logic [ID_BITS-1:0]    client_mem [SLOTS];
  logic                  mem_we;
  logic [SLOTS-1:0]      valid_q, valid_d;
  logic [SLOTS-1:0]      alive_q, alive_d;
  logic [CNT_W-1:0]      count_q, count_d;

  status_e               status_q, status_d;
  logic [IDX_W-1:0]      assigned_q, assigned_d;

  // Result register.
  logic                  out_valid_q;
  logic [STATUS_W-1:0]   out_status_q;
  logic [ASSIGN_W-1:0]   out_assigned_q;
  logic [OCC_W-1:0]      out_count_q;
  logic                  out_all_q;
  logic [MASK_W-1:0]     out_mask_q;

  logic                  hit;
  logic                  free_seen;
  logic                  in_range;
  logic [IDX_W-1:0]      sel;
  logic [SLOTS-1:0]      silent;

  assign stat_o.load_scan = (mode_i == MODE_SUB);
  assign stat_o.scan_done = rvalid_q && (ridx_q == LAST_IDX);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  // Compare one slot per cycle against the requested id.
  assign hit       = rvalid_q && valid_q[ridx_q] && (rdata_q == id_q);
  assign free_seen = rvalid_q && !valid_q[ridx_q];

  always_comb begin
    present_d    = present_q | hit;
    free_found_d = free_found_q | free_seen;
    free_idx_d   = (free_seen && !free_found_q) ? ridx_q : free_idx_q;
    if (cmd_i.load) begin
      present_d    = 1'b0;
      free_found_d = 1'b0;
    end
  end

  assign sel      = idx_q[IDX_W-1:0];
  assign in_range = (idx_q < SLOTS_LIM);

  always_comb begin
    valid_d    = valid_q;
    alive_d    = alive_q;
    count_d    = count_q;
    status_d   = status_q;
    assigned_d = assigned_q;
    mem_we     = 1'b0;
    if (cmd_i.exec) begin
      status_d   = ST_OK;
      assigned_d = '0;
      unique case (mode_q)
        MODE_SUB: begin
          if (present_q) begin
            status_d = ST_PRESENT;
          end else if (!free_found_q) begin
            status_d = ST_FULL;
          end else begin
            mem_we              = 1'b1;
            valid_d[free_idx_q] = 1'b1;
            alive_d[free_idx_q] = 1'b1;
            count_d             = count_q + 1'b1;
            assigned_d          = free_idx_q;
          end
        end
        MODE_UNSUB: begin
          if (!in_range) begin
            status_d = ST_RANGE;
          end else if (!valid_q[sel]) begin
            status_d = ST_EMPTY;
          end else begin
            valid_d[sel] = 1'b0;
            alive_d[sel] = 1'b0;
            count_d      = count_q - 1'b1;
          end
        end
        MODE_KICK: begin
          if (!in_range) begin
            status_d = ST_RANGE;
          end else begin
            alive_d[sel] = 1'b1;
          end
        end
        MODE_PERIOD: begin
          status_d = ST_OK;
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
    // The period-end mask is reported from the flags before this clear.
    if (cmd_i.report && (mode_q == MODE_PERIOD)) begin
      alive_d = '0;
    end
  end

  assign silent = valid_q & ~alive_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q      <= 1'b0;
      rvalid_q     <= 1'b0;
      valid_q      <= '0;
      alive_q      <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      present_q    <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      valid_q      <= valid_d;
      alive_q      <= alive_d;
      count_q      <= count_d;
      present_q    <= present_d;
      free_found_q <= free_found_d;
      rvalid_q     <= issue_q;
      if (cmd_i.load) begin
        issue_q <= (mode_i == MODE_SUB);
      end else if (issue_q && (addr_q == LAST_IDX)) begin
        issue_q <= 1'b0;
      end
      if (cmd_i.report) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_e'(mode_i);
      id_q   <= ID_BITS'(client_id_i);
      idx_q  <= slot_index_i;
      addr_q <= '0;
    end else if (issue_q) begin
      addr_q <= addr_q + 1'b1;
    end
    ridx_q     <= addr_q;
    free_idx_q <= free_idx_d;
    status_q   <= status_d;
    assigned_q <= assigned_d;
    if (cmd_i.report) begin
      out_status_q   <= status_q;
      out_assigned_q <= ASSIGN_W'(assigned_q);
      out_count_q    <= OCC_W'(count_q);
      out_all_q      <= ~|silent;
      out_mask_q     <= MASK_W'(silent);
    end
  end

  // Client id store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      client_mem[free_idx_q] <= id_q;
    end
    rdata_q <= client_mem[addr_q];
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign assigned_slot_o  = out_assigned_q;
  assign occupied_count_o = out_count_q;
  assign all_responsive_o = out_all_q;
  assign silent_mask_o    = out_mask_q;

endmodule

### rtl/multi_client_watchdog_table.sv
`timescale 1ns / 1ps
// Channel  Handshake              Beat contents
// -------  ---------------------  ---------------------------------------------------
// in       in_valid_i/in_ready_o  mode_i, client_id_i, slot_index_i
// out      out_valid_o/out_ready_i status_o, assigned_slot_o, occupied_count_o,
//                                 all_responsive_o, silent_mask_o
//
// A subscribe beat runs the id scan, reading one client id memory entry per cycle,
// before its update; unsubscribe, kick and period-end beats skip the scan and go
// through capture, update and report only. A new beat is taken only after the last one reports.
// Reset clears all slots, alive flags and the occupancy count at once; no clearing pass.
// A stalled result holds in the output register and delays only the report step.
`include "multi_client_watchdog_table_defines.svh"

module multi_client_watchdog_table #(
  parameter int SLOTS   = mcwt_pkg::SLOTS_DEF,
  parameter int ID_BITS = mcwt_pkg::ID_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [mcwt_pkg::MODE_W-1:0]       mode_i,
  input  logic [mcwt_pkg::CLIENT_W-1:0]     client_id_i,
  input  logic [mcwt_pkg::SLOT_IDX_W-1:0]   slot_index_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mcwt_pkg::STATUS_W-1:0]     status_o,
  output logic [mcwt_pkg::ASSIGN_W-1:0]     assigned_slot_o,
  output logic [mcwt_pkg::OCC_W-1:0]        occupied_count_o,
  output logic                              all_responsive_o,
  output logic [mcwt_pkg::MASK_W-1:0]       silent_mask_o
);
  import mcwt_pkg::*;

  // The controller sequences each beat through capture, an optional scan of the
  // client id memory, the table update and the report into the result register.
  // The datapath owns the slot table, the scan pipeline and the result register.
  ctrl_cmd_t  cmd;
  dp_status_t stat;

  mcwt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mcwt_dp #(
    .SLOTS   (SLOTS),
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .mode_i           (mode_i),
    .client_id_i      (client_id_i),
    .slot_index_i     (slot_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .assigned_slot_o  (assigned_slot_o),
    .occupied_count_o (occupied_count_o),
    .all_responsive_o (all_responsive_o),
    .silent_mask_o    (silent_mask_o)
  );

  // The controller issues at most one step command per cycle.
  `MCWT_ASSERT(a_cmd_exclusive, $onehot0({cmd.load, cmd.exec, cmd.report}), "overlapping commands")

  // Once a beat is taken, the block stays busy for at least the next cycle.
  `MCWT_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready after accept")

  // A full-table status is only reported while every slot is occupied.
  `MCWT_ASSERT(a_full_count, (out_valid_o && (status_o == ST_FULL)) |-> (occupied_count_o == OCC_W'(SLOTS)), "full with free slot")

  // Any silent slot rules out the all-responsive indication.
  `MCWT_ASSERT_NEVER(a_silent_vs_all, out_valid_o && (silent_mask_o != '0) && all_responsive_o, "silent slot while all responsive")

endmodule

### dv/watchdog_table_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the watchdog table, keeps its own copy of the slot
// table and compares every result beat with the report that it predicts.
module watchdog_table_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [mcwt_pkg::MODE_W-1:0]     mode_i,
  input  logic [mcwt_pkg::CLIENT_W-1:0]   client_id_i,
  input  logic [mcwt_pkg::SLOT_IDX_W-1:0] slot_index_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [mcwt_pkg::STATUS_W-1:0]   status_i,
  input  logic [mcwt_pkg::ASSIGN_W-1:0]   assigned_slot_i,
  input  logic [mcwt_pkg::OCC_W-1:0]      occupied_count_i,
  input  logic                            all_responsive_i,
  input  logic [mcwt_pkg::MASK_W-1:0]     silent_mask_i,
  output int                              mismatch_count_o,
  output int                              pending_o
);
  import mcwt_pkg::*;

  localparam int NUM_SLOTS = SLOTS_DEF;
  localparam int ID_W      = ID_BITS_DEF;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    status_e               status;
    logic [ASSIGN_W-1:0]   slot;
    logic [OCC_W-1:0]      occupied;
    logic                  all_resp;
    logic [MASK_W-1:0]     silent;
  } table_report_t;

  table_report_t      expected_reports[$];
  logic               slot_taken[NUM_SLOTS];
  logic [ID_W-1:0]    slot_owner[NUM_SLOTS];
  logic               slot_kicked[NUM_SLOTS];
  logic [OCC_W-1:0]   members;
  int                 errors;

  // Applies one request beat to the shadow table and returns its report.
  task automatic update_table(input mode_e mode, input logic [CLIENT_W-1:0] client,
                              input logic [SLOT_IDX_W-1:0] idx,
                              output table_report_t rpt);
    logic [ID_W-1:0]   id;
    int                free_slot;
    logic              present;
    logic [MASK_W-1:0] silent;
    logic              any_silent;
    rpt        = '0;
    rpt.status = ST_OK;
    id         = client[ID_W-1:0];
    free_slot  = -1;
    present    = 1'b0;
    case (mode)
      MODE_SUB: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_taken[i] && slot_owner[i] == id) present = 1'b1;
          if (!slot_taken[i] && free_slot < 0) free_slot = i;
        end
        if (present) begin
          rpt.status = ST_PRESENT;
        end else if (free_slot < 0) begin
          rpt.status = ST_FULL;
        end else begin
          slot_taken[free_slot]  = 1'b1;
          slot_owner[free_slot]  = id;
          slot_kicked[free_slot] = 1'b1;
          members++;
          rpt.slot = free_slot[ASSIGN_W-1:0];
        end
      end
      MODE_UNSUB: begin
        if (idx >= NUM_SLOTS) begin
          rpt.status = ST_RANGE;
        end else if (!slot_taken[idx]) begin
          rpt.status = ST_EMPTY;
        end else begin
          slot_taken[idx]  = 1'b0;
          slot_kicked[idx] = 1'b0;
          members--;
        end
      end
      MODE_KICK: begin
        // A kick on a free slot still sets its flag.
        if (idx >= NUM_SLOTS) rpt.status = ST_RANGE;
        else slot_kicked[idx] = 1'b1;
      end
      default: ;
    endcase
    silent     = '0;
    any_silent = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (slot_taken[i] && !slot_kicked[i]) begin
        any_silent = 1'b1;
        if (i < MASK_W) silent[i] = 1'b1;
      end
    end
    // The period end reports the flags as they were, then clears them.
    if (mode == MODE_PERIOD) begin
      for (int i = 0; i < NUM_SLOTS; i++) slot_kicked[i] = 1'b0;
    end
    rpt.occupied = members;
    rpt.all_resp = !any_silent;
    rpt.silent   = silent;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    table_report_t want;
    table_report_t got;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_taken[i]  = 1'b0;
        slot_owner[i]  = '0;
        slot_kicked[i] = 1'b0;
      end
      members = '0;
      errors  = 0;
      expected_reports.delete();
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      // The result side goes first; a report never leaves in the cycle its
      // request beat is taken.
      if (out_valid_i && out_ready_i) begin
        got = '{status_e'(status_i), assigned_slot_i, occupied_count_i,
                all_responsive_i, silent_mask_i};
        if (expected_reports.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: result beat with no request waiting: status %0d", $time,
                     status_i);
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
              $display("%0t: mismatch: status %0d/%0d slot %0d/%0d count %0d/%0d",
                       $time, want.status, status_i, want.slot, assigned_slot_i,
                       want.occupied, occupied_count_i);
              $display("  all_resp %0b/%0b silent %h/%h (expected/actual)",
                       want.all_resp, all_responsive_i, want.silent, silent_mask_i);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        update_table(mode_e'(mode_i), client_id_i, slot_index_i, want);
        expected_reports.push_back(want);
      end
      mismatch_count_o <= errors;
      pending_o        <= expected_reports.size();
    end
  end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

// Top of the watchdog table bench. It builds the request stream, drives the
// result-side stall pattern, runs the no-progress watchdog and prints the
// verdict. All prediction and comparison lives in the checker instance.
module testbench;
  import mcwt_pkg::*;

  localparam int RANDOM_BEATS = 450;
  localparam int CHUNK_BEATS  = 40;
  // Cycles without any beat on either channel before the run is declared hung.
  // The limit is many times the longest honest subscribe, receiver stall or sender gap.
  localparam int HANG_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 40;

  // Traffic flavors of the random part. Each chunk of beats picks one, so the
  // table swings between nearly empty, full and everything in between.
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BALANCED
  } traffic_mix_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [MODE_W-1:0]     mode_i;
  logic [CLIENT_W-1:0]   client_id_i;
  logic [SLOT_IDX_W-1:0] slot_index_i;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [STATUS_W-1:0]   status_o;
  logic [ASSIGN_W-1:0]   assigned_slot_o;
  logic [OCC_W-1:0]      occupied_count_o;
  logic                  all_responsive_o;
  logic [MASK_W-1:0]     silent_mask_o;
  int                    mismatch_count;
  int                    pending;

  int                    burst_left = 0;
  int                    idle_cycles;
  logic [CLIENT_W-1:0]   recent_ids[$];
  traffic_mix_e          mix;

  // Receiver stall pattern state.
  int                    ready_style = 0;
  int                    style_left  = 0;
  int                    hold_left   = 0;

  always #5 clk_i = ~clk_i;

  multi_client_watchdog_table dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .mode_i,
    .client_id_i,
    .slot_index_i,
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .assigned_slot_o,
    .occupied_count_o,
    .all_responsive_o,
    .silent_mask_o
  );

  watchdog_table_checker table_check (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i       (in_ready_o),
    .mode_i,
    .client_id_i,
    .slot_index_i,
    .out_valid_i      (out_valid_o),
    .out_ready_i,
    .status_i         (status_o),
    .assigned_slot_i  (assigned_slot_o),
    .occupied_count_i (occupied_count_o),
    .all_responsive_i (all_responsive_o),
    .silent_mask_i    (silent_mask_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // The receiver switches between four stall styles, each kept for a random while:
  // always ready, a coin flip per cycle, mostly stalled, and long holds of
  // either level. The always-ready style gives stretches with no stalls.
  always @(negedge clk_i) begin
    if (style_left == 0) begin
      ready_style = $urandom_range(0, 3);
      style_left  = $urandom_range(20, 80);
    end else begin
      style_left--;
    end
    case (ready_style)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: begin
        if (hold_left == 0) begin
          out_ready_i <= ~out_ready_i;
          hold_left = $urandom_range(1, 25);
        end else begin
          hold_left--;
        end
      end
    endcase
  end

  // Sends one request beat. It is called at a falling edge and returns at the
  // falling edge after the beat was taken, with valid still high so that a
  // back-to-back beat in the same burst keeps it high. Between bursts the
  // valid line drops for a random gap in most cases.
  task automatic send_request(input mode_e mode, input logic [CLIENT_W-1:0] id,
                              input logic [SLOT_IDX_W-1:0] idx);
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    mode_i       = mode;
    client_id_i  = id;
    slot_index_i = idx;
    in_valid_i   = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Holds the request side off until every report of the beats sent so far
  // has come back out.
  task automatic wait_until_drained();
    in_valid_i = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Builds one random request. Subscribes often reuse a recent id or pick
  // from a tiny id range so that duplicates are common; indexes are mostly
  // real slots, with a share above the table and the top value itself.
  task automatic random_request(input traffic_mix_e flavor);
    int                    roll;
    int                    sub_cut;
    int                    unsub_cut;
    int                    kick_cut;
    mode_e                 mode;
    logic [CLIENT_W-1:0]   id;
    logic [SLOT_IDX_W-1:0] idx;
    case (flavor)
      MIX_FILL:  begin sub_cut = 70; unsub_cut = 75; kick_cut = 90; end
      MIX_DRAIN: begin sub_cut = 10; unsub_cut = 70; kick_cut = 90; end
      default:   begin sub_cut = 30; unsub_cut = 55; kick_cut = 85; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < sub_cut) mode = MODE_SUB;
    else if (roll < unsub_cut) mode = MODE_UNSUB;
    else if (roll < kick_cut) mode = MODE_KICK;
    else mode = MODE_PERIOD;

    roll = $urandom_range(0, 99);
    if (roll < 25 && recent_ids.size() != 0)
      id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
    else if (roll < 35)
      id = CLIENT_W'($urandom_range(0, 7));
    else
      id = CLIENT_W'($urandom_range(0, 65535));

    roll = $urandom_range(0, 99);
    if (roll < 3) idx = 8'hFF;
    else if (roll < 10) idx = SLOT_IDX_W'($urandom_range(SLOTS_DEF, 254));
    else idx = SLOT_IDX_W'($urandom_range(0, SLOTS_DEF - 1));

    if (mode == MODE_SUB) begin
      recent_ids.push_back(id);
      if (recent_ids.size() > SLOTS_DEF) void'(recent_ids.pop_front());
    end
    send_request(mode, id, idx);
  endtask

  // Hang detector: any beat on either channel restarts the count.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < HANG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    mode_i       = MODE_SUB;
    client_id_i  = '0;
    slot_index_i = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part. First the empty table: a period end with nobody
    // subscribed, unsubscribes of a free slot and of an index past the table,
    // kicks past the table, and a kick on a free slot.
    send_request(MODE_PERIOD, 16'h1234, 8'd0);
    send_request(MODE_UNSUB, 16'h0000, 8'd0);
    send_request(MODE_UNSUB, 16'h0000, 8'hFF);
    send_request(MODE_KICK, 16'h0000, 8'd16);
    send_request(MODE_KICK, 16'h0000, 8'hFF);
    send_request(MODE_KICK, 16'h0000, 8'd3);
    // Subscribes with the extreme ids, a duplicate, and one more client.
    send_request(MODE_SUB, 16'h0000, 8'hFF);
    send_request(MODE_SUB, 16'hFFFF, 8'h00);
    send_request(MODE_SUB, 16'h0000, 8'd7);
    send_request(MODE_SUB, 16'hA5A5, 8'd0);
    // Every fresh subscriber is alive, so this period end reports nobody.
    send_request(MODE_PERIOD, 16'h0000, 8'd0);
    // Only slot 1 kicks; the next period end must flag slots 0 and 2.
    send_request(MODE_KICK, 16'h0000, 8'd1);
    send_request(MODE_PERIOD, 16'hFFFF, 8'hFF);
    // Free slot 0, try again on the now free slot, and take it back with a
    // new id through the first-free search.
    send_request(MODE_UNSUB, 16'h0000, 8'd0);
    send_request(MODE_UNSUB, 16'h0000, 8'd0);
    send_request(MODE_SUB, 16'h5A5A, 8'd0);
    // The last real slot and the first index past it.
    send_request(MODE_KICK, 16'h0000, 8'd15);
    send_request(MODE_UNSUB, 16'h0000, 8'd15);
    send_request(MODE_UNSUB, 16'h0000, 8'd16);
    send_request(MODE_PERIOD, 16'h0000, 8'd0);
    send_request(MODE_SUB, 16'hFFFF, 8'd0);

    // Let the whole directed part come out before random traffic begins.
    wait_until_drained();

    // Random part. The first chunk fills the table so that the full case is
    // reached early; every hundred beats the sender waits for a full drain.
    mix = MIX_FILL;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % CHUNK_BEATS == 0 && n != 0) mix = traffic_mix_e'($urandom_range(0, 2));
      if (n % 100 == 99) wait_until_drained();
      random_request(mix);
    end

    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatch_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/mcwt_pkg.sv
rtl/mcwt_ctrl.sv
rtl/mcwt_dp.sv
rtl/multi_client_watchdog_table.sv
dv/watchdog_table_checker.sv
dv/testbench.sv
